// ===== sv/diff_drive_wheel_cmd_and_odometry_unit_assert.svh =====
// Assertion macros for the wheel command and odometry block.
// Bodies are empty when SYNTHESIS is defined.
`ifndef DIFF_DRIVE_WHEEL_CMD_AND_ODOMETRY_UNIT_ASSERT_SVH
`define DIFF_DRIVE_WHEEL_CMD_AND_ODOMETRY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is low
`define DDWC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
// Checked property, also during reset
`define DDWC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDWC_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define DDWC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/ddwc_pkg.sv =====
`default_nettype none
package ddwc_pkg;

  // CORDIC iteration count (8..32)
  localparam int CORDIC_ITERS = 16;

  // datapath widths
  localparam int DW     = 48;   // CORDIC / multiplier operand width
  localparam int PW     = 80;   // product width
  localparam int Q_W    = 15;   // goal quotient magnitude bits

  // fixed constants
  localparam logic [31:0] K_Q20     = 32'd636751;
  localparam logic [31:0] VEL_SCALE = 32'd1000000;
  localparam logic [63:0] VEL_DIV   = 64'd65536000000;
  localparam logic [63:0] SAT_LIM   = 64'd32767 * VEL_DIV;
  localparam logic [Q_W-1:0] Q_MAX  = '1;

  // divide by 65536e6 = 2^22 * 15625: drop 22 bits, then multiply by
  // ceil(2^43 / 15625) and keep bits from 43 up (exact below 2^29)
  localparam int          G_SHIFT   = 22;
  localparam int          Q_LSB     = 43;
  localparam logic [31:0] VEL_RECIP = 32'd562949954;

  // register indexes
  localparam logic [2:0] REG_HALF_TRACK = 3'd0;
  localparam logic [2:0] REG_VEL_GAIN   = 3'd1;
  localparam logic [2:0] REG_UM_PER_CNT = 3'd2;
  localparam logic [2:0] REG_ANG_PER_CNT = 3'd3;
  localparam logic [2:0] REG_JUMP_THR   = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_M_HT, ST_M_V, ST_M_G, ST_M_Q, ST_DFIN,
    ST_M_LEN, ST_M_STEP, ST_CORD, ST_M_KX, ST_M_KY, ST_APPLY, ST_FIN
  } state_t;

  // arctangent table, 2^32 per turn
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // saturate a 49-bit sum to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [DW:0] v);
    logic signed [31:0] r;
    if (v > $signed((DW+1)'(32'sh7FFFFFFF))) r = 32'sh7FFFFFFF;
    else if (v < -$signed((DW+1)'(33'sh080000000))) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round a 2^30-scale value to Q1.15 and saturate
  function automatic logic signed [15:0] rnd_q15(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    logic signed [15:0] r;
    t = (v + DW'(48'sd16384)) >>> 15;
    if (t > DW'(48'sd32767)) r = 16'sh7FFF;
    else if (t < -DW'(48'sd32768)) r = 16'sh8000;
    else r = t[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/ddwc_mul.sv =====
`default_nettype none
// Signed by unsigned multiplier, 16 bits of b per cycle; done rises when p holds the product
module ddwc_mul import ddwc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] a,
  input  wire logic        [31:0]   b,
  output logic                      done,
  output logic signed [PW-1:0]      p
);

  logic signed [DW-1:0] a_r;
  logic        [31:0]   b_r;
  logic        [2:0]    ph_r;
  logic signed [64:0]   pp_r;
  logic signed [PW-1:0] acc_r;
  logic                 done_r;
  logic        [15:0]   bsel;
  logic signed [64:0]   pp_w;

  // partial product of one half of b
  assign bsel = ph_r[0] ? b_r[15:0] : b_r[31:16];
  assign pp_w = a_r * $signed({1'b0, bsel});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[1:0], start};
      done_r <= ph_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_r[0] || ph_r[1]) pp_r <= pp_w;
    if (ph_r[1]) acc_r <= {{(PW-65){pp_r[64]}}, pp_r};
    if (ph_r[2]) acc_r <= acc_r + ({{(PW-65){pp_r[64]}}, pp_r} <<< 16);
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule
`default_nettype wire

// ===== sv/ddwc_cordic.sv =====
`default_nettype none
// Iterative rotation of (len, 0) by a binary angle, one step per cycle, no gain fix
module ddwc_cordic import ddwc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [DW-1:0] len,
  input  wire logic        [31:0]   ang,
  output logic                      done,
  output logic signed [DW-1:0]      x_out,
  output logic signed [DW-1:0]      y_out
);

  localparam int CNT_W = $clog2(CORDIC_ITERS);
  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF    = 34'sd2147483648;

  logic signed [DW-1:0] x_r, y_r;
  logic signed [33:0]   z_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic signed [33:0]   z0;
  logic signed [DW-1:0] xs, ys;
  logic signed [33:0]   at;

  assign z0 = {{2{ang[31]}}, ang};
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = $signed({2'b00, atan_bam(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(CORDIC_ITERS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // quadrant pre-rotation, then micro-rotations
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      y_r   <= '0;
      if (z0 > QUARTER) begin
        z_r <= z0 - HALF;
        x_r <= -len;
      end else if (z0 < -QUARTER) begin
        z_r <= z0 + HALF;
        x_r <= -len;
      end else begin
        z_r <= z0;
        x_r <= len;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;

endmodule
`default_nettype wire

// ===== sv/diff_drive_wheel_cmd_and_odometry_unit.sv =====
`default_nettype none
// Differential-drive wheel command and odometry unit.
// Input channel (in_valid/in_ready): one beat per control tick or clear request.
// Output channel (out_valid/out_ready): one result beat for every input beat,
// in order, held in an output register until taken.
// Configuration: APB-style write/read of five registers at byte address 4*i,
// pready always high; write only while the block is idle.
// A clear goes straight to the finish state; a tick that resyncs computes
// the goal velocities only; a full tick also updates heading, position and
// quaternion. The work is done by the one shared multiplier (six products
// for the goal velocities, twelve for a full tick, the divide by 65536e6
// being a reciprocal product per wheel) and the CORDIC unit, run once for
// travel and once for the quaternion.
// in_ready is high only between items; a new item may be taken while the
// previous result still waits on out_ready. If the receiver stalls, the
// finished item waits in the last state until the output register frees.
// Reset (synchronous, rst_n low) restores register defaults, zeroes counts,
// heading and position, sets the quaternion to identity and drops out_valid.
`include "diff_drive_wheel_cmd_and_odometry_unit_assert.svh"
module diff_drive_wheel_cmd_and_odometry_unit import ddwc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [15:0] in_linear_mm_s,
  input  wire logic signed [15:0] in_angular_mrad_s,
  input  wire logic signed [31:0] in_right_count,
  input  wire logic signed [31:0] in_left_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_right_goal_vel,
  output logic signed [15:0]      out_left_goal_vel,
  output logic signed [31:0]      out_pose_x_um,
  output logic signed [31:0]      out_pose_y_um,
  output logic        [31:0]      out_heading_bam,
  output logic signed [15:0]      out_quat_z,
  output logic signed [15:0]      out_quat_w,
  output logic                    out_resynced
);

  state_t state_r, state_nxt;

  // configuration
  logic [19:0] half_track_r;
  logic [23:0] vel_gain_r;
  logic [25:0] um_per_cnt_r;
  logic [31:0] ang_per_cnt_r;
  logic [30:0] jump_thr_r;

  // architectural state
  logic [31:0]        prev_r_r, prev_l_r;
  logic [32:0]        heading_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [15:0] qz_r, qw_r;

  // working registers
  logic               wait_r, out_valid_r, side_r, pass_r;
  logic signed [15:0] v_r, om_r;
  logic signed [31:0] dr_r, dl_r;
  logic signed [37:0] p1_r, wr_r, wl_r;
  logic signed [63:0] gp_r;
  logic               resync_r;
  logic [Q_W-1:0]     q_r;
  logic signed [15:0] rg_r, lg_r;
  logic signed [DW-1:0] len_r, cx_r, cy_r, kx_r, ky_r;

  // output register
  logic signed [15:0] o_rg_r, o_lg_r, o_qz_r, o_qw_r;
  logic signed [31:0] o_px_r, o_py_r;
  logic [31:0]        o_hd_r;
  logic               o_rs_r;

  // shared units
  logic                 mul_start, mul_done, cor_start, cor_done;
  logic signed [DW-1:0] mul_a, cor_len, cor_x, cor_y;
  logic [31:0]          mul_b, cor_ang;
  logic signed [PW-1:0] mul_p;

  // combinational helpers
  logic               wr_en, jump, fin_go;
  logic [31:0]        mag_r, mag_l;
  logic [63:0]        gmag;
  logic               goal_neg, goal_sat;
  logic [Q_W-1:0]     goal_mag;
  logic signed [15:0] goal;
  logic signed [32:0] dsum, ddif;
  logic signed [PW-1:0] rnd20;

  ddwc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  ddwc_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .len(cor_len), .ang(cor_ang),
    .done(cor_done), .x_out(cor_x), .y_out(cor_y)
  );

  // APB access
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_HALF_TRACK:  prdata = {12'd0, half_track_r};
      REG_VEL_GAIN:    prdata = {8'd0, vel_gain_r};
      REG_UM_PER_CNT:  prdata = {6'd0, um_per_cnt_r};
      REG_ANG_PER_CNT: prdata = ang_per_cnt_r;
      REG_JUMP_THR:    prdata = {1'b0, jump_thr_r};
      default:         prdata = '0;
    endcase
  end

  // deltas and jump test
  assign dsum  = {dr_r[31], dr_r} + {dl_r[31], dl_r};
  assign ddif  = {dr_r[31], dr_r} - {dl_r[31], dl_r};
  assign mag_r = dr_r[31] ? 32'(-dr_r) : dr_r;
  assign mag_l = dl_r[31] ? 32'(-dl_r) : dl_r;
  assign jump  = (mag_r >= {1'b0, jump_thr_r}) && (mag_l >= {1'b0, jump_thr_r});

  // goal velocity: magnitude, saturation and sign of the scaled product
  assign gmag     = gp_r[63] ? 64'(-gp_r) : gp_r;
  assign goal_neg = gp_r[63];
  assign goal_sat = gmag >= SAT_LIM;
  assign goal_mag = goal_sat ? Q_MAX : q_r;
  assign goal     = goal_neg ? -$signed({1'b0, goal_mag}) : $signed({1'b0, goal_mag});
  assign rnd20    = mul_p + PW'(1 << 19);
  assign fin_go   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = in_func ? ST_FIN : ST_M_HT;
      ST_M_HT:   if (mul_done) state_nxt = ST_M_V;
      ST_M_V:    if (mul_done) state_nxt = ST_M_G;
      ST_M_G:    if (mul_done) state_nxt = ST_M_Q;
      ST_M_Q:    if (mul_done) state_nxt = ST_DFIN;
      ST_DFIN:   state_nxt = !side_r ? ST_M_G : (jump ? ST_FIN : ST_M_LEN);
      ST_M_LEN:  if (mul_done) state_nxt = ST_M_STEP;
      ST_M_STEP: if (mul_done) state_nxt = ST_CORD;
      ST_CORD:   if (cor_done) state_nxt = ST_M_KX;
      ST_M_KX:   if (mul_done) state_nxt = ST_M_KY;
      ST_M_KY:   if (mul_done) state_nxt = ST_APPLY;
      ST_APPLY:  state_nxt = pass_r ? ST_FIN : ST_CORD;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // unit control and operand selection
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    cor_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cor_len   = pass_r ? DW'(48'sd1073741824) : len_r;
    cor_ang   = pass_r ? heading_r[32:1] : heading_r[31:0];
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_M_HT: begin
        mul_start = !wait_r;
        mul_a     = DW'(om_r);
        mul_b     = {12'd0, half_track_r};
      end
      ST_M_V: begin
        mul_start = !wait_r;
        mul_a     = DW'(v_r);
        mul_b     = VEL_SCALE;
      end
      ST_M_G: begin
        mul_start = !wait_r;
        mul_a     = side_r ? DW'(wl_r) : DW'(wr_r);
        mul_b     = {8'd0, vel_gain_r};
      end
      // quotient by reciprocal product
      ST_M_Q: begin
        mul_start = !wait_r;
        mul_a     = DW'(gmag[63:G_SHIFT]);
        mul_b     = VEL_RECIP;
      end
      ST_M_LEN: begin
        mul_start = !wait_r;
        mul_a     = DW'(dsum);
        mul_b     = {6'd0, um_per_cnt_r};
      end
      ST_M_STEP: begin
        mul_start = !wait_r;
        mul_a     = DW'(ddif);
        mul_b     = ang_per_cnt_r;
      end
      ST_CORD: cor_start = !wait_r;
      ST_M_KX: begin
        mul_start = !wait_r;
        mul_a     = cx_r;
        mul_b     = K_Q20;
      end
      ST_M_KY: begin
        mul_start = !wait_r;
        mul_a     = cy_r;
        mul_b     = K_Q20;
      end
      default: ;
    endcase
  end

  // control, configuration and pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wait_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      half_track_r  <= 20'd62500;
      vel_gain_r    <= 24'd136640;
      um_per_cnt_r  <= 26'd2010620;
      ang_per_cnt_r <= 32'd42949673;
      jump_thr_r    <= 31'd2048;
      prev_r_r      <= '0;
      prev_l_r      <= '0;
      heading_r     <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      qz_r          <= '0;
      qw_r          <= 16'sd32767;
    end else begin
      state_r <= state_nxt;
      if (mul_start || cor_start) wait_r <= 1'b1;
      else if (mul_done || cor_done) wait_r <= 1'b0;

      if (wr_en) begin
        case (paddr[4:2])
          REG_HALF_TRACK:  half_track_r  <= pwdata[19:0];
          REG_VEL_GAIN:    vel_gain_r    <= pwdata[23:0];
          REG_UM_PER_CNT:  um_per_cnt_r  <= pwdata[25:0];
          REG_ANG_PER_CNT: ang_per_cnt_r <= pwdata;
          REG_JUMP_THR:    jump_thr_r    <= pwdata[30:0];
          default: ;
        endcase
      end

      if (state_r == ST_FIN && fin_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid && in_func) begin
            pos_x_r <= '0;
            pos_y_r <= '0;
            qz_r    <= '0;
            qw_r    <= 16'sd32767;
          end else if (in_valid) begin
            prev_r_r <= in_right_count;
            prev_l_r <= in_left_count;
          end
        end
        ST_M_STEP: if (mul_done) heading_r <= heading_r + mul_p[40:8];
        ST_APPLY: begin
          if (!pass_r) begin
            pos_x_r <= sat32((DW+1)'(pos_x_r) + (DW+1)'(kx_r));
            pos_y_r <= sat32((DW+1)'(pos_y_r) + (DW+1)'(ky_r));
          end else begin
            qw_r <= rnd_q15(kx_r);
            qz_r <= rnd_q15(ky_r);
          end
        end
        default: ;
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          v_r      <= in_linear_mm_s;
          om_r     <= in_angular_mrad_s;
          dr_r     <= in_right_count - $signed(prev_r_r);
          dl_r     <= in_left_count - $signed(prev_l_r);
          side_r   <= 1'b0;
          pass_r   <= 1'b0;
          resync_r <= 1'b0;
          rg_r     <= '0;
          lg_r     <= '0;
        end
      end
      ST_M_HT: if (mul_done) p1_r <= mul_p[37:0];
      ST_M_V: begin
        if (mul_done) begin
          wr_r <= mul_p[37:0] + p1_r;
          wl_r <= mul_p[37:0] - p1_r;
        end
      end
      ST_M_G: if (mul_done) gp_r <= mul_p[63:0];
      ST_M_Q: if (mul_done) q_r <= mul_p[Q_LSB+Q_W-1:Q_LSB];
      ST_DFIN: begin
        side_r <= 1'b1;
        if (!side_r) rg_r <= goal;
        else begin
          lg_r     <= goal;
          resync_r <= jump;
        end
      end
      ST_M_LEN: if (mul_done) len_r <= mul_p[DW+16:17] + DW'(mul_p[16]);
      ST_CORD: begin
        if (cor_done) begin
          cx_r <= cor_x;
          cy_r <= cor_y;
        end
      end
      ST_M_KX: if (mul_done) kx_r <= rnd20[DW+19:20];
      ST_M_KY: if (mul_done) ky_r <= rnd20[DW+19:20];
      ST_APPLY: pass_r <= 1'b1;
      ST_FIN: begin
        if (fin_go) begin
          o_rg_r <= rg_r;
          o_lg_r <= lg_r;
          o_px_r <= pos_x_r;
          o_py_r <= pos_y_r;
          o_hd_r <= heading_r[31:0];
          o_qz_r <= qz_r;
          o_qw_r <= qw_r;
          o_rs_r <= resync_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_right_goal_vel = o_rg_r;
  assign out_left_goal_vel  = o_lg_r;
  assign out_pose_x_um      = o_px_r;
  assign out_pose_y_um      = o_py_r;
  assign out_heading_bam    = o_hd_r;
  assign out_quat_z         = o_qz_r;
  assign out_quat_w         = o_qw_r;
  assign out_resynced       = o_rs_r;

  // checks
  `DDWC_ASSERT_RST(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `DDWC_ASSERT_RST(a_result_from_fin, clk, rst_n, $rose(out_valid) |-> $past(state_r == ST_FIN), "result outside finish")
  `DDWC_ASSERT_RST(a_mul_done_waited, clk, rst_n, mul_done |-> wait_r, "product not requested")
  `DDWC_ASSERT_RST(a_cordic_in_state, clk, rst_n, cor_done |-> (state_r == ST_CORD), "rotation done out of state")

endmodule
`default_nettype wire
